### rtl/ffpl_pkg.sv
// Shared types and constants for the force field parameter lookup block.
// Used by the controller, the datapath and the top level.
package ffpl_pkg;
  localparam int unsigned MAX_TYPES = 100;
  localparam int unsigned KEY_W = 25;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned TYPE_W = $clog2(MAX_TYPES);
  localparam int unsigned NUM_KINDS = 5;

  typedef enum logic [2:0] {
    KIND_BOND = 3'd0,
    KIND_ANGLE = 3'd1,
    KIND_TORSION = 3'd2,
    KIND_IMPROPER = 3'd3,
    KIND_HBOND = 3'd4
  } kind_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [2:0] REG_NUM_TYPES = 3'd0;
  // Table counts follow in kind order
  localparam logic [2:0] REG_COUNT_BASE = 3'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;   // capture input item
    logic key_mul1;    // first key product stage
    logic key_mul2;    // second key product stage
    logic bs_init;     // start binary search with selected key
    logic bs_step;     // issue a probe read
    logic bs_cmp;      // compare returned probe
    logic sel_wild;    // search uses wildcard key
    logic scan_init;   // start duplicate scan
    logic scan_step;   // issue a scan read
    logic scan_cmp;    // compare scanned entry
    logic write_key;   // store a key
    logic set_res_bs;  // result from search
    logic set_res_scan;
    logic set_res_zero;
    logic held_from_scan;
    logic held_clear;
  } ffpl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_load;
    logic load_ok;
    logic kind_ok;
    logic dihedral;
    logic bs_done;
    logic bs_found;
    logic scan_done;
  } ffpl_sts_t;
endpackage

### rtl/force_field_parameter_lookup_core.sv
// Force field parameter lookup: loads sorted key tables, looks up indices.
// A load gives no word. A lookup runs a binary search of at most
// log2(count) + 1 probes; a torsion/improper hitting its full key then runs
// the duplicate scan, one missing it runs the wildcard search. One word in
// flight; the next is accepted once the controller is idle, while a
// finished word may still wait in the output register. No clearing pass:
// key memory is undefined until written. Reset clears controller state,
// held index and the table counts, and sets the type count to 100.
module force_field_parameter_lookup_core import ffpl_pkg::*; #(
  parameter int unsigned MAX_KEYS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_slot[8:0], entry_key[33:9], type_a[40:34], type_b[47:41],
  // type_c[54:48], type_d[61:55], repeat_next[62]
  input  logic [63:0] in_tdata,
  // op[0], kind[3:1]
  input  logic [7:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // param_index[9:0]
  output logic [15:0] out_tdata,
  // not_found[0]
  output logic [7:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  ffpl_cmd_t cmd;
  ffpl_sts_t sts;
  logic busy, res_valid, in_fire;
  logic [IDX_W-1:0] res_index;
  logic [TYPE_W-1:0] num_types_r;
  logic [IDX_W-1:0] count_r [NUM_KINDS];
  logic out_v_r;
  logic [IDX_W-1:0] out_idx_r;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_types_r <= 7'd100;
      for (int k = 0; k < NUM_KINDS; k++) count_r[k] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_NUM_TYPES) num_types_r <= cfg_data[6:0];
      else if (cfg_index <= 3'(NUM_KINDS)) count_r[cfg_index - REG_COUNT_BASE] <= cfg_data;
    end
  end

  ffpl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(!out_v_r),
    .sts(sts), .cmd(cmd), .busy(busy), .res_valid(res_valid)
  );

  ffpl_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .op(in_tuser[0:0]), .kind(in_tuser[3:1]), .entry_slot(in_tdata[8:0]),
    .entry_key(in_tdata[33:9]), .type_a(in_tdata[40:34]),
    .type_b(in_tdata[47:41]), .type_c(in_tdata[54:48]),
    .type_d(in_tdata[61:55]), .repeat_next(in_tdata[62]),
    .num_types(num_types_r), .count_sel(count_r), .res_index(res_index)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_valid && !out_v_r) begin
      out_v_r <= 1'b1;
      out_idx_r <= res_index;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {6'd0, out_idx_r};
  assign out_tuser = {7'd0, (out_idx_r == '0)};

  // Output word holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("out hold");
  // No input accepted while the controller is busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("accept while busy");
  // Flag agrees with index
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tdata[9:0] == 10'd0))) else $error("flag");
endmodule

### rtl/ffpl_ctrl.sv
// Controller state machine for the parameter lookup block.
// Depends on ffpl_pkg for the command and status structs.
module ffpl_ctrl import ffpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_free,
  input  ffpl_sts_t sts,
  output ffpl_cmd_t cmd,
  output logic      busy,
  output logic      res_valid
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_MUL1, S_MUL2, S_BS_INIT, S_BS_RD, S_BS_WAIT, S_BS_CMP,
    S_SC_INIT, S_SC_RD, S_SC_CMP, S_WILD, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   wild_r, wild_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    wild_nxt = wild_r;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_item = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        wild_nxt = 1'b0;
        if (sts.is_load) begin
          cmd.write_key = sts.load_ok;
          state_nxt = S_IDLE;
        end else if (!sts.kind_ok) begin
          cmd.set_res_zero = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.key_mul1 = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.key_mul2 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: state_nxt = S_BS_INIT;
      S_BS_INIT: begin
        cmd.bs_init = 1'b1;
        cmd.sel_wild = wild_r;
        state_nxt = S_BS_RD;
      end
      S_BS_RD: begin
        if (sts.bs_done) begin
          if (sts.dihedral && !wild_r) begin
            state_nxt = S_WILD;
          end else begin
            cmd.set_res_bs = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.bs_step = 1'b1;
          state_nxt = S_BS_WAIT;
        end
      end
      S_BS_WAIT: state_nxt = S_BS_CMP;
      S_BS_CMP: begin
        cmd.bs_cmp = 1'b1;
        state_nxt = S_BS_RD;
      end
      S_WILD: begin
        if (sts.bs_found) begin
          cmd.scan_init = 1'b1;
          state_nxt = S_SC_RD;
        end else begin
          cmd.held_clear = 1'b1;
          wild_nxt = 1'b1;
          state_nxt = S_BS_INIT;
        end
      end
      S_SC_INIT: state_nxt = S_SC_RD;
      S_SC_RD: begin
        if (sts.scan_done) begin
          cmd.set_res_scan = 1'b1;
          cmd.held_from_scan = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt = S_SC_CMP;
        end
      end
      S_SC_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt = S_SC_RD;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wild_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wild_r <= wild_nxt;
    end
  end
endmodule

### rtl/ffpl_dp.sv
// Datapath for the parameter lookup: key arithmetic, key memory, search.
// Depends on ffpl_pkg; driven by ffpl_ctrl commands.
module ffpl_dp import ffpl_pkg::*; #(
  parameter int unsigned MAX_KEYS = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffpl_cmd_t         cmd,
  output ffpl_sts_t         sts,
  input  logic [0:0]        op,
  input  logic [2:0]        kind,
  input  logic [8:0]        entry_slot,
  input  logic [KEY_W-1:0]  entry_key,
  input  logic [TYPE_W-1:0] type_a,
  input  logic [TYPE_W-1:0] type_b,
  input  logic [TYPE_W-1:0] type_c,
  input  logic [TYPE_W-1:0] type_d,
  input  logic              repeat_next,
  input  logic [TYPE_W-1:0] num_types,
  input  logic [IDX_W-1:0]  count_sel [NUM_KINDS],
  output logic [IDX_W-1:0]  res_index
);
  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned MEM_AW = $clog2(NUM_KINDS * MAX_KEYS);
  localparam logic [PW-1:0] MAX_CNT = PW'(MAX_KEYS);

  // Captured item
  logic              op_r;
  logic [2:0]        kind_r;
  logic [8:0]        slot_r;
  logic [KEY_W-1:0]  ekey_r;
  logic [TYPE_W-1:0] a_r, b_r, c_r, d_r;
  logic              rep_r;

  // Key pipeline
  logic [13:0] p1_r, p2_r;       // pairs, up to 8256
  logic [13:0] f_r;              // N(N+1)/2
  logic [27:0] full_r;           // full key, below 2^28
  logic [13:0] wild_r;
  logic [IDX_W-1:0] held_r;

  function automatic logic [13:0] pair_f(input logic [TYPE_W-1:0] x,
                                         input logic [TYPE_W-1:0] y);
    logic [TYPE_W-1:0] hi, lo;
    logic [14:0] t;
    hi = (x > y) ? x : y;
    lo = (x > y) ? y : x;
    t = 15'(hi) * 15'(15'(hi) + 15'd1);
    return 14'(t >> 1) + 14'(lo) + 14'd1;
  endfunction

  // Search state
  logic [PW:0]   lo_r, hi_r;  // signed-free range: hi stored +1
  logic [PW-1:0] mid_r;
  logic [PW-1:0] found_r;
  logic          bs_found_r;
  logic [27:0]   skey_r;
  logic [PW-1:0] cnt;
  logic [PW-1:0] scan_r;
  logic [PW-1:0] scan_res_r;
  logic [KEY_W-1:0] rd_r;
  logic [MEM_AW-1:0] rd_addr;
  logic [MEM_AW-1:0] rd_addr_w;

  logic [KEY_W-1:0] mem [NUM_KINDS * MAX_KEYS];

  logic [IDX_W-1:0] cnt_raw;
  assign cnt_raw = (kind_r < 3'(NUM_KINDS)) ? count_sel[kind_r] : '0;
  assign cnt = (32'(cnt_raw) > MAX_KEYS) ? MAX_CNT : PW'(cnt_raw);

  logic [PW:0] mid_c;
  assign mid_c = (lo_r + hi_r - 1'b1) >> 1;

  assign rd_addr = MEM_AW'(32'(kind_r) * MAX_KEYS) +
                   MEM_AW'(cmd.scan_step ? scan_r : mid_c[PW-1:0]);
  assign rd_addr_w = MEM_AW'(32'(kind_r) * MAX_KEYS) + MEM_AW'(slot_r);

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write_key) mem[rd_addr_w] <= ekey_r;
    if (cmd.bs_step || cmd.scan_step) rd_r <= mem[rd_addr];
  end

  // Capture item and compute keys
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r <= op[0]; kind_r <= kind; slot_r <= entry_slot; ekey_r <= entry_key;
      a_r <= type_a; b_r <= type_b; c_r <= type_c; d_r <= type_d;
      rep_r <= repeat_next;
    end
    if (cmd.key_mul1) begin
      f_r <= 14'((15'(num_types) * (15'(num_types) + 15'd1)) >> 1);
      case (kind_r)
        KIND_ANGLE: begin
          p1_r <= pair_f(c_r, a_r);
          p2_r <= 14'(b_r) + 14'd1;
        end
        KIND_TORSION: begin
          p1_r <= pair_f(c_r, b_r);
          p2_r <= pair_f(d_r, a_r);
        end
        KIND_IMPROPER: begin
          p1_r <= pair_f(d_r, a_r);
          p2_r <= pair_f(c_r, b_r);
        end
        default: begin
          p1_r <= pair_f(b_r, a_r);
          p2_r <= '0;
        end
      endcase
    end
    if (cmd.key_mul2) begin
      wild_r <= p1_r;
      case (kind_r)
        KIND_ANGLE: full_r <= 28'(21'(num_types) * 21'(p1_r)) + 28'(p2_r);
        KIND_TORSION, KIND_IMPROPER: full_r <= 28'(p2_r) * 28'(f_r) + 28'(p1_r);
        default: full_r <= 28'(p1_r);
      endcase
    end
  end

  // Binary search and duplicate scan
  always_ff @(posedge clk) begin
    if (cmd.bs_init) begin
      lo_r <= '0;
      hi_r <= (PW+1)'(cnt);
      bs_found_r <= 1'b0;
      found_r <= '0;
      skey_r <= cmd.sel_wild ? 28'(wild_r) : full_r;
    end
    if (cmd.bs_step) mid_r <= mid_c[PW-1:0];
    if (cmd.bs_cmp) begin
      if (28'(rd_r) == skey_r) begin
        bs_found_r <= 1'b1;
        found_r <= mid_r + 1'b1;
      end else if (28'(rd_r) < skey_r) begin
        lo_r <= (PW+1)'(mid_r) + 1'b1;
      end else begin
        hi_r <= (PW+1)'(mid_r);
      end
    end
    if (cmd.scan_init) begin
      scan_r <= '0;
      scan_res_r <= '0;
    end
    if (cmd.scan_step) scan_r <= scan_r + 1'b1;
    if (cmd.scan_cmp) begin
      if (28'(rd_r) == full_r && IDX_W'(scan_r) != held_r) scan_res_r <= scan_r;
    end
    if (cmd.set_res_bs) res_index <= IDX_W'(found_r);
    if (cmd.set_res_scan) res_index <= IDX_W'(scan_res_r);
    if (cmd.set_res_zero) res_index <= '0;
  end

  // Held index for repeated dihedral terms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.held_clear) begin
      held_r <= '0;
    end else if (cmd.held_from_scan) begin
      held_r <= rep_r ? IDX_W'(scan_res_r) : '0;
    end
  end

  assign sts.is_load = (op_r == OP_LOAD);
  assign sts.load_ok = (kind_r < 3'(NUM_KINDS)) && (32'(slot_r) < MAX_KEYS);
  assign sts.kind_ok = (kind_r < 3'(NUM_KINDS));
  assign sts.dihedral = (kind_r == KIND_TORSION) || (kind_r == KIND_IMPROPER);
  assign sts.bs_done = bs_found_r || (lo_r >= hi_r);
  assign sts.bs_found = bs_found_r;
  assign sts.scan_done = (scan_r >= cnt);
endmodule

### sim/testbench.sv
// Self-checking testbench for force_field_parameter_lookup_core.
// Loads key tables, programs counts and type range, checks every lookup
// against a local predictor. Depends on rtl/ffpl_pkg.sv and the core RTL.
module testbench import ffpl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 512;
  localparam int unsigned LOAD_SETTLE = 20;
  localparam int unsigned END_SETTLE = 50;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned TOTAL_WORDS = 1700;

  typedef struct {
    logic       op;
    logic [2:0] kind;
    logic [8:0] slot;
    logic [24:0] key;
    logic [6:0] a, b, c, d;
    logic       rep;
  } word_t;

  typedef struct {
    logic [9:0] idx;
    logic       nf;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [7:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [7:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  force_field_parameter_lookup_core u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  // predictor state
  logic [24:0] table_mem [5][TABLE_DEPTH];
  int unsigned cnt_cfg [5];
  int unsigned types_cfg = 100;
  logic [9:0]  held_idx = '0;

  // stimulus bookkeeping
  word_t   pending_words[$];
  answer_t expected_index_q[$];
  word_t   tuple_pool[$];
  bit      written [5][TABLE_DEPTH];
  word_t   cur_word;
  bit      in_sent = 0;
  int      errors = 0;
  int      lookups_done = 0;
  int      loads_done = 0;
  int      phases_done = 0;
  longint unsigned cycles = 0;

  int burst_left = 0, gap_left = 0;
  int rdy_mode = 0, rdy_left = 0;

  function automatic logic [63:0] pack_data(word_t w);
    return {1'b0, w.rep, w.d, w.c, w.b, w.a, w.key, w.slot};
  endfunction

  function automatic logic [7:0] pack_user(word_t w);
    return {4'd0, w.kind, w.op};
  endfunction

  function automatic logic [63:0] pair_code(logic [63:0] x, logic [63:0] y);
    logic [63:0] hi, lo;
    hi = x > y ? x : y;
    lo = x > y ? y : x;
    return hi * (hi + 1) / 2 + lo + 1;
  endfunction

  // primary key of a term: the only key for two- and three-atom kinds
  function automatic logic [63:0] term_key(word_t w, int unsigned n);
    logic [63:0] f;
    f = 64'(n) * 64'(n + 1) / 2;
    case (w.kind)
      KIND_ANGLE: return 64'(n) * pair_code(64'(w.c), 64'(w.a)) + 64'(w.b) + 1;
      KIND_TORSION:
        return pair_code(64'(w.c), 64'(w.b)) + pair_code(64'(w.d), 64'(w.a)) * f;
      KIND_IMPROPER:
        return pair_code(64'(w.d), 64'(w.a)) + pair_code(64'(w.c), 64'(w.b)) * f;
      default: return pair_code(64'(w.b), 64'(w.a));
    endcase
  endfunction

  function automatic logic [63:0] wildcard_key(word_t w);
    return (w.kind == KIND_TORSION) ? pair_code(64'(w.c), 64'(w.b))
                                    : pair_code(64'(w.d), 64'(w.a));
  endfunction

  function automatic int unsigned table_len(int k);
    return cnt_cfg[k] > TABLE_DEPTH ? TABLE_DEPTH : cnt_cfg[k];
  endfunction

  function automatic int unsigned search_table(int k, logic [63:0] key);
    int lo, hi, mid;
    lo = 0;
    hi = int'(table_len(k)) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (64'(table_mem[k][mid]) == key) return mid + 1;
      if (64'(table_mem[k][mid]) < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return 0;
  endfunction

  // advance the local copy by one accepted word, queue its answer if any
  task automatic predict_index(word_t w);
    int unsigned res;
    logic [63:0] full;
    answer_t ans;
    res = 0;
    if (w.op == OP_LOAD) begin
      if (w.kind < NUM_KINDS) table_mem[w.kind][w.slot] = w.key;
      loads_done++;
      return;
    end
    if (w.kind < NUM_KINDS) begin
      full = term_key(w, types_cfg);
      if (w.kind == KIND_TORSION || w.kind == KIND_IMPROPER) begin
        if (search_table(w.kind, full) != 0) begin
          for (int j = 0; j < table_len(w.kind); j++)
            if (64'(table_mem[w.kind][j]) == full && 10'(j + 1) != held_idx)
              res = j + 1;
          held_idx = w.rep ? 10'(res) : 10'd0;
        end else begin
          held_idx = '0;
          res = search_table(w.kind, wildcard_key(w));
        end
      end else begin
        res = search_table(w.kind, full);
      end
    end
    ans.idx = 10'(res);
    ans.nf = (res == 0);
    expected_index_q.push_back(ans);
    lookups_done++;
  endtask

  task automatic report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // sample handshakes, predict, check
  always @(posedge clk) begin
    answer_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      if (rst_n && in_tvalid && in_tready) begin
        predict_index(cur_word);
        in_sent = 1;
      end
      if (rst_n && cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NUM_TYPES) types_cfg = cfg_data[6:0];
        else if (cfg_index <= NUM_KINDS) cnt_cfg[cfg_index - REG_COUNT_BASE] = cfg_data;
      end
      if (rst_n && out_tvalid && out_tready) begin
        got.idx = out_tdata[9:0];
        got.nf = out_tuser[0];
        if (expected_index_q.size() == 0) begin
          report($sformatf("unexpected word idx=%0d nf=%0b", got.idx, got.nf));
        end else begin
          want = expected_index_q.pop_front();
          if (got.idx !== want.idx)
            report($sformatf("param_index %0d, want %0d", got.idx, want.idx));
          if (got.nf !== want.nf)
            report($sformatf("not_found %0b, want %0b", got.nf, want.nf));
        end
      end
    end
  end

  // drive input words in bursts, stall the result side by mode
  always @(negedge clk) begin
    logic v;
    v = in_tvalid;
    if (!rst_n) begin
      v = 1'b0;
    end else begin
      if (in_sent) begin
        in_sent = 0;
        v = 1'b0;
      end
      if (!v) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
        if (burst_left > 0 && pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_tdata <= pack_data(cur_word);
          in_tuser <= pack_user(cur_word);
          v = 1'b1;
          burst_left--;
        end else if (burst_left == 0 && gap_left > 0) begin
          gap_left--;
        end
      end
    end
    in_tvalid <= v;
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_left = $urandom_range(16, 200);
    end
    rdy_left--;
    case (rdy_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic cfg_write(logic [2:0] idx, logic [9:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_tvalid || expected_index_q.size() != 0)
      @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic push_load(int k, int slot, logic [24:0] key);
    word_t w;
    w = '{op: OP_LOAD, kind: 3'(k), slot: 9'(slot), key: key,
          a: 7'($urandom), b: 7'($urandom), c: 7'($urandom), d: 7'($urandom),
          rep: 1'($urandom)};
    if (k < NUM_KINDS) written[k][slot] = 1;
    pending_words.push_back(w);
  endtask

  function automatic word_t random_tuple(int k, int n, int hi_code);
    word_t w;
    w = '{op: OP_LOOKUP, kind: 3'(k), slot: 9'($urandom), key: 25'($urandom),
          a: 7'($urandom_range(0, hi_code)), b: 7'($urandom_range(0, hi_code)),
          c: 7'($urandom_range(0, hi_code)), d: 7'($urandom_range(0, hi_code)),
          rep: 1'b0};
    return w;
  endfunction

  // fill all five tables from terms of this type range and random keys, then program counts
  task automatic load_phase(int n, int cnt_max, bit big, bit extremes, bit unsorted);
    logic [63:0] keys[$];
    word_t t;
    int cnt, dup, prefix;
    int unsigned cnt_val;
    tuple_pool.delete();
    for (int k = 0; k < NUM_KINDS; k++) begin
      keys.delete();
      cnt = (big && k == KIND_BOND) ? TABLE_DEPTH : $urandom_range(0, cnt_max);
      if (extremes && cnt > 0) begin
        t = random_tuple(k, n, 0);
        tuple_pool.push_back(t);
        keys.push_back(term_key(t, n));
        t.a = 7'(n - 1); t.b = 7'(n - 1); t.c = 7'(n - 1); t.d = 7'(n - 1);
        tuple_pool.push_back(t);
        keys.push_back(term_key(t, n));
      end
      while (keys.size() < cnt) begin
        case ($urandom_range(0, 9))
          0, 1: keys.push_back(64'($urandom_range(0, 25507550)));
          2: keys.push_back(64'($urandom) & 64'h1FF_FFFF);
          3: begin
            t = random_tuple(k, n, n - 1);
            tuple_pool.push_back(t);
            keys.push_back(k == KIND_TORSION || k == KIND_IMPROPER ?
                           wildcard_key(t) : term_key(t, n));
          end
          default: begin
            t = random_tuple(k, n, n - 1);
            tuple_pool.push_back(t);
            dup = (k == KIND_TORSION || k == KIND_IMPROPER) ? $urandom_range(1, 3) : 1;
            repeat (dup) keys.push_back(term_key(t, n));
          end
        endcase
      end
      while (keys.size() > cnt) void'(keys.pop_back());
      if (!unsorted) keys.sort();
      foreach (keys[i]) push_load(k, i, 25'(keys[i]));
    end
    // loads of kinds outside the table set are dropped by the block
    push_load($urandom_range(5, 7), $urandom_range(0, 511), 25'($urandom));
    wait_idle();
    cfg_write(REG_NUM_TYPES, 10'(n));
    for (int k = 0; k < NUM_KINDS; k++) begin
      prefix = 0;
      while (prefix < TABLE_DEPTH && written[k][prefix]) prefix++;
      cnt_val = $urandom_range(0, prefix < cnt_max ? prefix : cnt_max);
      if (big && k == KIND_BOND) cnt_val = 1023;   // saturates to table depth
      else if (big || $urandom_range(0, 3) != 0) cnt_val = prefix;
      if (prefix < TABLE_DEPTH && cnt_val > prefix) cnt_val = prefix;
      cfg_write(REG_COUNT_BASE + 3'(k), 10'(cnt_val));
    end
  endtask

  // mostly terms from the tables, repeated dihedrals, some noise
  task automatic lookup_phase(int n, int total);
    word_t t;
    int made, reps;
    made = 0;
    while (made < total) begin
      if ($urandom_range(0, 9) < 7 && tuple_pool.size() > 0) begin
        t = tuple_pool[$urandom_range(0, tuple_pool.size() - 1)];
        if ($urandom_range(0, 3) == 0) t.kind = 3'($urandom_range(0, 4));
        reps = (t.kind == KIND_TORSION || t.kind == KIND_IMPROPER) ?
               $urandom_range(1, 4) : 1;
        for (int r = 0; r < reps; r++) begin
          t.rep = (r < reps - 1) ? 1'b1 : 1'($urandom_range(0, 3) == 0);
          t.slot = 9'($urandom);
          t.key = 25'($urandom);
          pending_words.push_back(t);
          made++;
        end
      end else begin
        t = random_tuple($urandom_range(0, 7), n,
                         $urandom_range(0, 3) == 0 ? 127 : n - 1);
        t.rep = 1'($urandom);
        if ($urandom_range(0, 7) == 0) begin
          push_load(t.kind, $urandom_range(0, 511), 25'($urandom));
        end else begin
          pending_words.push_back(t);
          made++;
        end
      end
    end
    wait_idle();
    phases_done++;
  endtask

  initial begin
    word_t t;
    int n;
    for (int k = 0; k < NUM_KINDS; k++) cnt_cfg[k] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty tables after reset: every kind, legal or not, finds nothing
    for (int k = 0; k < 8; k++) begin
      t = random_tuple(k, 100, 0);
      pending_words.push_back(t);
      t.a = 7'd127; t.b = 7'd127; t.c = 7'd127; t.d = 7'd127;
      pending_words.push_back(t);
    end
    wait_idle();

    // extreme type codes at full and minimal type range
    load_phase(100, 12, 0, 1, 0);
    lookup_phase(100, 25);
    load_phase(1, 8, 0, 1, 0);
    lookup_phase(1, 40);

    // full bond table, bond count above the depth
    load_phase(100, 64, 1, 1, 0);
    lookup_phase(100, 40);

    // random settings until enough words went through
    while (lookups_done + loads_done < TOTAL_WORDS) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 100);
      load_phase(n, $urandom_range(1, 48), 0, $urandom_range(0, 1),
                 $urandom_range(0, 7) == 0);
      lookup_phase(n, 150);
    end

    repeat (END_SETTLE) @(posedge clk);
    $display("covered %0d lookups and %0d loads over %0d table settings",
             lookups_done, loads_done, phases_done);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
